// File: design/vdc_pkg.sv
package vdc_pkg;

  // Default table sizes.
  localparam int MAX_PARTICLES_DEF = 256;
  localparam int MAX_LINKS_DEF     = 512;

  // Iterative unit: one result bit per step.
  localparam int ITER_STEPS = 32;
  localparam int ITER_CW    = $clog2(ITER_STEPS);

  // Configuration register reset values.
  localparam logic signed [31:0] GRAVITY_RST = 32'sd32768;
  localparam logic [15:0]        DAMPING_RST = 16'd64881;
  localparam logic signed [31:0] FLOOR_RST   = 32'sd39321600;
  localparam logic [3:0]         PASSES_RST  = 4'd5;

  localparam logic signed [34:0] SAT_MAX = 35'sd2147483647;
  localparam logic signed [34:0] SAT_MIN = -35'sd2147483648;

  typedef enum logic [2:0] {
    KIND_ADD_PARTICLE = 3'd0,
    KIND_ADD_LINK     = 3'd1,
    KIND_TOGGLE_FIXED = 3'd2,
    KIND_SET_POSITION = 3'd3,
    KIND_CLEAR        = 3'd4,
    KIND_STEP         = 3'd5,
    KIND_READ_PART    = 3'd6,
    KIND_READ_LINK    = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_INDEX = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_GRAVITY = 2'd0,
    REG_DAMPING = 2'd1,
    REG_FLOOR   = 2'd2,
    REG_PASSES  = 2'd3
  } reg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_AL1, S_AL2, S_AL3, S_TG1, S_RP1, S_RL1,
    S_INT0, S_INT1, S_INT2, S_INT3,
    S_RLX0, S_RLX1, S_RLX2, S_RLX3, S_RLX4, S_RLX5, S_RLX6, S_RLX7,
    S_RLX8, S_RLX9, S_RLX10,
    S_LEN0, S_LEN1, S_LEN2, S_LEN3,
    S_FL0, S_FL1, S_RESP
  } state_t;

  // Control of the shared root / divide unit.
  typedef struct packed {
    logic start;
    logic sqrt_op;
  } iter_ctl_t;

  function automatic logic signed [34:0] sext35(input logic signed [31:0] v);
    return {{3{v[31]}}, v};
  endfunction

  function automatic logic signed [34:0] sext35w(input logic signed [32:0] v);
    return {{2{v[32]}}, v};
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) r = 32'sh7FFFFFFF;
    else if (v < SAT_MIN) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // Saturated b - a.
  function automatic logic signed [31:0] sdiff(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    return sat32(sext35(b) - sext35(a));
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    logic [31:0] r;
    r = v[31] ? 32'(-v) : 32'(v);
    return r;
  endfunction

endpackage

// File: design/vdc_ram.sv
module vdc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// File: design/vdc_mul.sv
module vdc_mul (
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic signed [65:0] prod
);

  // Registered signed multiply; the product appears in the cycle after the operands.
  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

// File: design/vdc_iter.sv
module vdc_iter import vdc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  iter_ctl_t   ctl,
  input  logic [63:0] operand,
  input  logic [32:0] divisor,
  output logic        done,
  output logic [31:0] result
);

  logic               busy;
  logic [ITER_CW-1:0] cnt;
  logic               sqrt_r;
  logic [63:0]        src;
  logic [35:0]        rem;
  logic [31:0]        acc;
  logic [32:0]        div_r;
  logic [35:0]        rem_sh;
  logic [35:0]        trial;
  logic               ge;

  // One digit step: square root takes two operand bits, division one.
  always_comb begin
    rem_sh = sqrt_r ? {rem[33:0], src[63:62]} : {rem[34:0], src[63]};
    trial  = sqrt_r ? {2'b00, acc, 2'b01} : {3'b000, div_r};
    ge     = (rem_sh >= trial);
  end

  // Step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == ITER_CW'(ITER_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath. The divide starts with the high word as remainder, since
  // the quotient is known to fit in 32 bits.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      sqrt_r <= ctl.sqrt_op;
      src    <= ctl.sqrt_op ? operand : {operand[31:0], 32'd0};
      rem    <= ctl.sqrt_op ? 36'd0 : {4'd0, operand[63:32]};
      acc    <= '0;
      div_r  <= divisor;
    end else if (busy) begin
      src <= sqrt_r ? {src[61:0], 2'b00} : {src[62:0], 1'b0};
      rem <= ge ? (rem_sh - trial) : rem_sh;
      acc <= {acc[30:0], ge};
    end
  end

  assign result = acc;

endmodule

// File: design/verlet_distance_constraint_solver_core.sv
// Verlet distance-constraint solver for 2D particles in signed Q16.16.
// Input channel (in_valid / in_stall) carries one command request: kind,
// index_a, index_b, pos_x, pos_y, fixed_in. The output channel (out_valid /
// out_stall) returns exactly one result request per command with status,
// indices, particle data and both table counts. in_stall is high while a
// command is in progress; one command is handled at a time.
// A step integrates every particle, runs solver_passes relaxation passes
// over the link table and then clamps the particles to the floor level;
// each link visit makes three 32-step passes through the shared root /
// divide unit. The result sits in an output register, so a stalled receiver
// holds only the next command's completion, not its acceptance.
// Configuration uses an APB-style port (gravity, damping, floor_level,
// solver_passes at byte addresses 0, 4, 8, 12); the user must write it
// only while the block is idle, and the block itself does not enforce this.
// Reset clears both counts and restores the register defaults; the
// particle and link memories are not cleared and are read only after
// being written.
module verlet_distance_constraint_solver_core import vdc_pkg::*; #(
  parameter int MAX_PARTICLES = MAX_PARTICLES_DEF,
  parameter int MAX_LINKS     = MAX_LINKS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         kind,
  input  logic [8:0]         index_a,
  input  logic [7:0]         index_b,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic               fixed_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic [7:0]         result_index,
  output logic [7:0]         result_index_b,
  output logic signed [31:0] read_x,
  output logic signed [31:0] read_y,
  output logic               read_fixed,
  output logic [8:0]         particle_count,
  output logic [9:0]         link_count,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int PAW = $clog2(MAX_PARTICLES);
  localparam int LAW = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;
  localparam int PCW = $clog2(MAX_PARTICLES + 1);
  localparam int LCW = $clog2(MAX_LINKS + 1);
  localparam int IW  = (PCW > 9) ? PCW : 9;
  localparam int LIW = (LCW > 9) ? LCW : 9;

  // Configuration registers.
  logic signed [31:0] gravity;
  logic [15:0]        damping;
  logic signed [31:0] floor_level;
  logic [3:0]         solver_passes;

  state_t state, state_next;

  // Captured request.
  kind_t              kind_r, kind_r_next;
  logic [8:0]         ia_r, ia_r_next;
  logic [7:0]         ib_r, ib_r_next;
  logic signed [31:0] pxin_r, pxin_r_next;
  logic signed [31:0] pyin_r, pyin_r_next;
  logic               fin_r, fin_r_next;

  // Table counts and walk counters.
  logic [PCW-1:0] np, np_next;
  logic [LCW-1:0] nl, nl_next;
  logic [PCW-1:0] idx_p, idx_p_next;
  logic [LCW-1:0] idx_l, idx_l_next;
  logic [3:0]     pc, pc_next;

  // Result being built.
  status_t            res_status, res_status_next;
  logic [7:0]         res_ri, res_ri_next;
  logic [7:0]         res_rib, res_rib_next;
  logic signed [31:0] res_x, res_x_next;
  logic signed [31:0] res_y, res_y_next;
  logic               res_f, res_f_next;

  // Working registers.
  logic signed [31:0] ax_r, ax_r_next;
  logic signed [31:0] ay_r, ay_r_next;
  logic signed [31:0] bx_r, bx_r_next;
  logic signed [31:0] by_r, by_r_next;
  logic               pa_r, pa_r_next;
  logic               pb_r, pb_r_next;
  logic [7:0]         ea_r, ea_r_next;
  logic [7:0]         eb_r, eb_r_next;
  logic [31:0]        len_r, len_r_next;
  logic signed [31:0] dx_r, dx_r_next;
  logic signed [31:0] dy_r, dy_r_next;
  logic [63:0]        sq_r, sq_r_next;
  logic [31:0]        d_r, d_r_next;
  logic signed [32:0] e_r, e_r_next;
  logic [32:0]        dv_r, dv_r_next;
  logic signed [32:0] mx_r, mx_r_next;
  logic signed [32:0] my_r, my_r_next;
  logic signed [31:0] vy_r, vy_r_next;
  logic signed [32:0] dampx_r, dampx_r_next;
  logic signed [31:0] cx_r, cx_r_next;
  logic signed [31:0] cy_r, cy_r_next;

  // Memory ports.
  logic [PAW-1:0] p_raddr, p_waddr;
  logic           cx_we, cy_we, px_we, py_we, pin_we;
  logic [31:0]    cx_wd, cy_wd, px_wd, py_wd;
  logic           pin_wd;
  logic [31:0]    cx_rd, cy_rd, px_rd, py_rd;
  logic           pin_rd;
  logic [LAW-1:0] l_raddr, l_waddr;
  logic           l_we;
  logic [15:0]    le_wd, le_rd;
  logic [31:0]    rl_wd, rl_rd;

  // Shared arithmetic.
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  iter_ctl_t          iter_ctl;
  logic [63:0]        iter_opnd;
  logic [32:0]        iter_div;
  logic               iter_done;
  logic [31:0]        iter_res;

  // Combinational helpers.
  logic signed [32:0] e_now;
  logic [31:0]        e_mag;
  logic signed [32:0] q_signed;
  logic               ld_out;

  vdc_ram #(.WIDTH(32), .DEPTH(MAX_PARTICLES)) u_cx_ram (
    .clk(clk), .we(cx_we), .waddr(p_waddr), .wdata(cx_wd), .raddr(p_raddr), .rdata(cx_rd));
  vdc_ram #(.WIDTH(32), .DEPTH(MAX_PARTICLES)) u_cy_ram (
    .clk(clk), .we(cy_we), .waddr(p_waddr), .wdata(cy_wd), .raddr(p_raddr), .rdata(cy_rd));
  vdc_ram #(.WIDTH(32), .DEPTH(MAX_PARTICLES)) u_px_ram (
    .clk(clk), .we(px_we), .waddr(p_waddr), .wdata(px_wd), .raddr(p_raddr), .rdata(px_rd));
  vdc_ram #(.WIDTH(32), .DEPTH(MAX_PARTICLES)) u_py_ram (
    .clk(clk), .we(py_we), .waddr(p_waddr), .wdata(py_wd), .raddr(p_raddr), .rdata(py_rd));
  vdc_ram #(.WIDTH(1), .DEPTH(MAX_PARTICLES)) u_pin_ram (
    .clk(clk), .we(pin_we), .waddr(p_waddr), .wdata(pin_wd), .raddr(p_raddr),
    .rdata(pin_rd));
  vdc_ram #(.WIDTH(16), .DEPTH(MAX_LINKS)) u_ends_ram (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(le_wd), .raddr(l_raddr), .rdata(le_rd));
  vdc_ram #(.WIDTH(32), .DEPTH(MAX_LINKS)) u_rest_ram (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(rl_wd), .raddr(l_raddr), .rdata(rl_rd));

  vdc_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));

  vdc_iter u_iter (
    .clk(clk), .rst(rst), .ctl(iter_ctl), .operand(iter_opnd), .divisor(iter_div),
    .done(iter_done), .result(iter_res));

  // Configuration port.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gravity       <= GRAVITY_RST;
      damping       <= DAMPING_RST;
      floor_level   <= FLOOR_RST;
      solver_passes <= PASSES_RST;
    end else if (psel && penable && pwrite) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_GRAVITY: gravity       <= pwdata;
        REG_DAMPING: damping       <= pwdata[15:0];
        REG_FLOOR:   floor_level   <= pwdata;
        REG_PASSES:  solver_passes <= pwdata[3:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_GRAVITY: prdata = gravity;
      REG_DAMPING: prdata = {16'd0, damping};
      REG_FLOOR:   prdata = floor_level;
      REG_PASSES:  prdata = {28'd0, solver_passes};
      default:     prdata = '0;
    endcase
  end

  assign in_stall = (state != S_IDLE);

  // Link error term and signed quotient.
  always_comb begin
    e_now    = $signed({1'b0, d_r}) - $signed({1'b0, len_r});
    e_mag    = e_r[32] ? 32'(-e_r) : e_r[31:0];
    q_signed = $signed({1'b0, iter_res});
  end

  assign ld_out = (state == S_RESP) && (!out_valid || !out_stall);

  // Sequencer: next state, memory and unit control, register updates.
  always_comb begin
    state_next      = state;
    kind_r_next     = kind_r;
    ia_r_next       = ia_r;
    ib_r_next       = ib_r;
    pxin_r_next     = pxin_r;
    pyin_r_next     = pyin_r;
    fin_r_next      = fin_r;
    np_next         = np;
    nl_next         = nl;
    idx_p_next      = idx_p;
    idx_l_next      = idx_l;
    pc_next         = pc;
    res_status_next = res_status;
    res_ri_next     = res_ri;
    res_rib_next    = res_rib;
    res_x_next      = res_x;
    res_y_next      = res_y;
    res_f_next      = res_f;
    ax_r_next       = ax_r;
    ay_r_next       = ay_r;
    bx_r_next       = bx_r;
    by_r_next       = by_r;
    pa_r_next       = pa_r;
    pb_r_next       = pb_r;
    ea_r_next       = ea_r;
    eb_r_next       = eb_r;
    len_r_next      = len_r;
    dx_r_next       = dx_r;
    dy_r_next       = dy_r;
    sq_r_next       = sq_r;
    d_r_next        = d_r;
    e_r_next        = e_r;
    dv_r_next       = dv_r;
    mx_r_next       = mx_r;
    my_r_next       = my_r;
    vy_r_next       = vy_r;
    dampx_r_next    = dampx_r;
    cx_r_next       = cx_r;
    cy_r_next       = cy_r;

    p_raddr = '0;
    p_waddr = '0;
    cx_we = 1'b0;
    cy_we = 1'b0;
    px_we = 1'b0;
    py_we = 1'b0;
    pin_we = 1'b0;
    cx_wd = '0;
    cy_wd = '0;
    px_wd = '0;
    py_wd = '0;
    pin_wd = 1'b0;
    l_raddr = '0;
    l_waddr = '0;
    l_we = 1'b0;
    le_wd = '0;
    rl_wd = '0;
    mul_a = '0;
    mul_b = '0;
    iter_ctl = '0;
    iter_opnd = '0;
    iter_div = '0;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          kind_r_next = kind_t'(kind);
          ia_r_next   = index_a;
          ib_r_next   = index_b;
          pxin_r_next = pos_x;
          pyin_r_next = pos_y;
          fin_r_next  = fixed_in;
          state_next  = S_DECODE;
        end
      end

      S_DECODE: begin
        res_status_next = ST_OK;
        res_ri_next     = '0;
        res_rib_next    = '0;
        res_x_next      = '0;
        res_y_next      = '0;
        res_f_next      = 1'b0;
        state_next      = S_RESP;
        case (kind_r)
          KIND_ADD_PARTICLE: begin
            if (np >= PCW'(MAX_PARTICLES)) begin
              res_status_next = ST_FULL;
            end else begin
              p_waddr = PAW'(np);
              cx_we = 1'b1;
              cy_we = 1'b1;
              px_we = 1'b1;
              py_we = 1'b1;
              pin_we = 1'b1;
              cx_wd = pxin_r;
              px_wd = pxin_r;
              cy_wd = pyin_r;
              py_wd = pyin_r;
              pin_wd = fin_r;
              res_ri_next = 8'(np);
              np_next = np + 1'b1;
            end
          end
          KIND_ADD_LINK: begin
            if (IW'(ia_r) >= IW'(np) || IW'(ib_r) >= IW'(np)) begin
              res_status_next = ST_BAD_INDEX;
            end else if (nl >= LCW'(MAX_LINKS)) begin
              res_status_next = ST_FULL;
            end else begin
              p_raddr = PAW'(ia_r);
              state_next = S_AL1;
            end
          end
          KIND_TOGGLE_FIXED: begin
            if (IW'(ia_r) >= IW'(np)) begin
              res_status_next = ST_BAD_INDEX;
            end else begin
              p_raddr = PAW'(ia_r);
              state_next = S_TG1;
            end
          end
          KIND_SET_POSITION: begin
            if (IW'(ia_r) >= IW'(np)) begin
              res_status_next = ST_BAD_INDEX;
            end else begin
              p_waddr = PAW'(ia_r);
              cx_we = 1'b1;
              cy_we = 1'b1;
              px_we = 1'b1;
              py_we = 1'b1;
              cx_wd = pxin_r;
              px_wd = pxin_r;
              cy_wd = pyin_r;
              py_wd = pyin_r;
            end
          end
          KIND_CLEAR: begin
            np_next = '0;
            nl_next = '0;
          end
          KIND_STEP: begin
            idx_p_next = '0;
            state_next = S_INT0;
          end
          KIND_READ_PART: begin
            if (IW'(ia_r) >= IW'(np)) begin
              res_status_next = ST_BAD_INDEX;
            end else begin
              p_raddr = PAW'(ia_r);
              state_next = S_RP1;
            end
          end
          KIND_READ_LINK: begin
            if (LIW'(ia_r) >= LIW'(nl)) begin
              res_status_next = ST_BAD_INDEX;
            end else begin
              l_raddr = LAW'(ia_r);
              state_next = S_RL1;
            end
          end
          default: ;
        endcase
      end

      // Add link: read both endpoints, measure, store.
      S_AL1: begin
        ax_r_next = cx_rd;
        ay_r_next = cy_rd;
        p_raddr = PAW'(ib_r);
        state_next = S_AL2;
      end
      S_AL2: begin
        dx_r_next = sdiff(ax_r, cx_rd);
        dy_r_next = sdiff(ay_r, cy_rd);
        state_next = S_LEN0;
      end
      S_AL3: begin
        l_waddr = LAW'(nl);
        l_we = 1'b1;
        le_wd = {ib_r, ia_r[7:0]};
        rl_wd = d_r;
        nl_next = nl + 1'b1;
        state_next = S_RESP;
      end

      S_TG1: begin
        p_waddr = PAW'(ia_r);
        pin_we = 1'b1;
        pin_wd = ~pin_rd;
        state_next = S_RESP;
      end

      S_RP1: begin
        res_x_next = cx_rd;
        res_y_next = cy_rd;
        res_f_next = pin_rd;
        state_next = S_RESP;
      end

      S_RL1: begin
        res_ri_next  = le_rd[7:0];
        res_rib_next = le_rd[15:8];
        state_next = S_RESP;
      end

      // Integration, one particle per visit.
      S_INT0: begin
        if (idx_p >= np) begin
          idx_l_next = '0;
          pc_next = '0;
          state_next = S_RLX0;
        end else begin
          p_raddr = PAW'(idx_p);
          state_next = S_INT1;
        end
      end
      S_INT1: begin
        cx_r_next = cx_rd;
        cy_r_next = cy_rd;
        if (pin_rd) begin
          idx_p_next = idx_p + 1'b1;
          state_next = S_INT0;
        end else begin
          vy_r_next = sdiff(py_rd, cy_rd);
          mul_a = $signed({sdiff(px_rd, cx_rd)[31], sdiff(px_rd, cx_rd)});
          mul_b = $signed({17'd0, damping});
          state_next = S_INT2;
        end
      end
      S_INT2: begin
        dampx_r_next = prod[48:16];
        mul_a = $signed({vy_r[31], vy_r});
        mul_b = $signed({17'd0, damping});
        state_next = S_INT3;
      end
      S_INT3: begin
        p_waddr = PAW'(idx_p);
        cx_we = 1'b1;
        cy_we = 1'b1;
        px_we = 1'b1;
        py_we = 1'b1;
        cx_wd = sat32(sext35(cx_r) + sext35w(dampx_r));
        cy_wd = sat32(sext35(cy_r) + sext35w(prod[48:16]) + sext35(gravity));
        px_wd = cx_r;
        py_wd = cy_r;
        idx_p_next = idx_p + 1'b1;
        state_next = S_INT0;
      end

      // Relaxation passes over the link table.
      S_RLX0: begin
        if (pc >= solver_passes) begin
          idx_p_next = '0;
          state_next = S_FL0;
        end else if (idx_l >= nl) begin
          pc_next = pc + 1'b1;
          idx_l_next = '0;
        end else begin
          l_raddr = LAW'(idx_l);
          state_next = S_RLX1;
        end
      end
      S_RLX1: begin
        ea_r_next = le_rd[7:0];
        eb_r_next = le_rd[15:8];
        len_r_next = rl_rd;
        if (IW'(le_rd[7:0]) >= IW'(np) || IW'(le_rd[15:8]) >= IW'(np)) begin
          idx_l_next = idx_l + 1'b1;
          state_next = S_RLX0;
        end else begin
          p_raddr = PAW'(le_rd[7:0]);
          state_next = S_RLX2;
        end
      end
      S_RLX2: begin
        ax_r_next = cx_rd;
        ay_r_next = cy_rd;
        pa_r_next = pin_rd;
        p_raddr = PAW'(eb_r);
        state_next = S_RLX3;
      end
      S_RLX3: begin
        bx_r_next = cx_rd;
        by_r_next = cy_rd;
        pb_r_next = pin_rd;
        dx_r_next = sdiff(ax_r, cx_rd);
        dy_r_next = sdiff(ay_r, cy_rd);
        state_next = S_LEN0;
      end
      S_RLX4: begin
        e_r_next = e_now;
        dv_r_next = (!pa_r && !pb_r) ? {d_r, 1'b0} : {1'b0, d_r};
        if (d_r == '0 || (pa_r && pb_r)) begin
          idx_l_next = idx_l + 1'b1;
          state_next = S_RLX0;
        end else begin
          mul_a = $signed({1'b0, mag32(dx_r)});
          mul_b = $signed({1'b0, (e_now[32] ? 32'(-e_now) : e_now[31:0])});
          state_next = S_RLX5;
        end
      end
      S_RLX5: begin
        iter_ctl.start = 1'b1;
        iter_ctl.sqrt_op = 1'b0;
        iter_opnd = prod[63:0];
        iter_div = dv_r;
        state_next = S_RLX6;
      end
      S_RLX6: begin
        if (iter_done) begin
          mx_r_next = (dx_r[31] ^ e_r[32]) ? -q_signed : q_signed;
          mul_a = $signed({1'b0, mag32(dy_r)});
          mul_b = $signed({1'b0, e_mag});
          state_next = S_RLX7;
        end
      end
      S_RLX7: begin
        iter_ctl.start = 1'b1;
        iter_ctl.sqrt_op = 1'b0;
        iter_opnd = prod[63:0];
        iter_div = dv_r;
        state_next = S_RLX8;
      end
      S_RLX8: begin
        if (iter_done) begin
          my_r_next = (dy_r[31] ^ e_r[32]) ? -q_signed : q_signed;
          state_next = S_RLX9;
        end
      end
      S_RLX9: begin
        p_waddr = PAW'(ea_r);
        cx_we = !pa_r;
        cy_we = !pa_r;
        cx_wd = sat32(sext35(ax_r) + sext35w(mx_r));
        cy_wd = sat32(sext35(ay_r) + sext35w(my_r));
        state_next = S_RLX10;
      end
      S_RLX10: begin
        p_waddr = PAW'(eb_r);
        cx_we = !pb_r;
        cy_we = !pb_r;
        cx_wd = sat32(sext35(bx_r) - sext35w(mx_r));
        cy_wd = sat32(sext35(by_r) - sext35w(my_r));
        idx_l_next = idx_l + 1'b1;
        state_next = S_RLX0;
      end

      // Length of (dx, dy): two squares, then the integer root.
      S_LEN0: begin
        mul_a = $signed({1'b0, mag32(dx_r)});
        mul_b = $signed({1'b0, mag32(dx_r)});
        state_next = S_LEN1;
      end
      S_LEN1: begin
        sq_r_next = prod[63:0];
        mul_a = $signed({1'b0, mag32(dy_r)});
        mul_b = $signed({1'b0, mag32(dy_r)});
        state_next = S_LEN2;
      end
      S_LEN2: begin
        iter_ctl.start = 1'b1;
        iter_ctl.sqrt_op = 1'b1;
        iter_opnd = sq_r + prod[63:0];
        state_next = S_LEN3;
      end
      S_LEN3: begin
        if (iter_done) begin
          d_r_next = iter_res;
          state_next = (kind_r == KIND_ADD_LINK) ? S_AL3 : S_RLX4;
        end
      end

      // Floor clamp, one particle per visit.
      S_FL0: begin
        if (idx_p >= np) begin
          state_next = S_RESP;
        end else begin
          p_raddr = PAW'(idx_p);
          state_next = S_FL1;
        end
      end
      S_FL1: begin
        p_waddr = PAW'(idx_p);
        if (!pin_rd && ($signed(cy_rd) > floor_level)) begin
          cy_we = 1'b1;
          py_we = 1'b1;
        end
        cy_wd = floor_level;
        py_wd = floor_level;
        idx_p_next = idx_p + 1'b1;
        state_next = S_FL0;
      end

      S_RESP: begin
        if (ld_out) state_next = S_IDLE;
      end

      default: state_next = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      np        <= '0;
      nl        <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      np    <= np_next;
      nl    <= nl_next;
      if (ld_out) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    kind_r     <= kind_r_next;
    ia_r       <= ia_r_next;
    ib_r       <= ib_r_next;
    pxin_r     <= pxin_r_next;
    pyin_r     <= pyin_r_next;
    fin_r      <= fin_r_next;
    idx_p      <= idx_p_next;
    idx_l      <= idx_l_next;
    pc         <= pc_next;
    res_status <= res_status_next;
    res_ri     <= res_ri_next;
    res_rib    <= res_rib_next;
    res_x      <= res_x_next;
    res_y      <= res_y_next;
    res_f      <= res_f_next;
    ax_r       <= ax_r_next;
    ay_r       <= ay_r_next;
    bx_r       <= bx_r_next;
    by_r       <= by_r_next;
    pa_r       <= pa_r_next;
    pb_r       <= pb_r_next;
    ea_r       <= ea_r_next;
    eb_r       <= eb_r_next;
    len_r      <= len_r_next;
    dx_r       <= dx_r_next;
    dy_r       <= dy_r_next;
    sq_r       <= sq_r_next;
    d_r        <= d_r_next;
    e_r        <= e_r_next;
    dv_r       <= dv_r_next;
    mx_r       <= mx_r_next;
    my_r       <= my_r_next;
    vy_r       <= vy_r_next;
    dampx_r    <= dampx_r_next;
    cx_r       <= cx_r_next;
    cy_r       <= cy_r_next;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (ld_out) begin
      status         <= res_status;
      result_index   <= res_ri;
      result_index_b <= res_rib;
      read_x         <= res_x;
      read_y         <= res_y;
      read_fixed     <= res_f;
      particle_count <= 9'(np);
      link_count     <= 10'(nl);
    end
  end

  // Counts stay within the tables.
  a_np_range: assert property (@(posedge clk) disable iff (rst)
    np <= PCW'(MAX_PARTICLES))
    else $error("particle count beyond table size");

  a_nl_range: assert property (@(posedge clk) disable iff (rst)
    nl <= LCW'(MAX_LINKS))
    else $error("link count beyond table size");

  // The root / divide unit finishes only while the sequencer waits on it.
  a_iter_done: assert property (@(posedge clk) disable iff (rst)
    iter_done |-> (state == S_LEN3 || state == S_RLX6 || state == S_RLX8))
    else $error("root/divide result arrived with no one waiting");

  // Counts change only in decode or when a link is stored; checked here for the particle count.
  a_np_change: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && np != $past(np)) |-> $past(state) == S_DECODE)
    else $error("particle count changed outside decode");

endmodule
